FILE: design/assert_macros.svh
// Assertion macros used by the checker file bps_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, held off while reset is high.
`define BPS_ASSERT(lbl, ck, rs, prop) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) \
    else $error("bps assertion failed");

// Clocked check that also runs during reset.
`define BPS_ASSERT_NR(lbl, ck, prop) \
  lbl: assert property (@(posedge ck) prop) \
    else $error("bps assertion failed");

`endif

FILE: design/bps_pkg.sv
package bps_pkg;

  localparam int unsigned Q14_W  = 15;
  localparam int unsigned ROOT_W = 31;
  localparam int unsigned REM_W  = 33;
  localparam int unsigned RAD_W  = 34;
  localparam int unsigned DNH_W  = 33;
  localparam int unsigned SQ_STEPS = 31;

  typedef logic [Q14_W-1:0] q14_t;

  localparam q14_t Q14_ONE = 15'd16384;

  // Q1.14 product, rounded half up
  function automatic q14_t q14_mul(input q14_t a, input q14_t b);
    logic [28:0] p;
    p = 29'(a) * 29'(b) + 29'd8192;
    return p[28:14];
  endfunction

endpackage

FILE: design/bps_udiv.sv
module bps_udiv #(
  parameter int unsigned NUM_W = 48,
  parameter int unsigned DEN_W = 32,
  parameter int unsigned Q_W   = 16
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [Q_W-1:0]   quo
);

  localparam int unsigned RW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  logic [RW-1:0]    rem [Q_W];
  logic [DEN_W-1:0] dv  [Q_W];
  logic [Q_W-1:0]   qb  [Q_W+1];
  logic             ovf [Q_W+1];

  // quotient too wide (or zero divisor) saturates
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= RW'(num);
      dv[0]  <= den;
      qb[0]  <= '0;
      ovf[0] <= RW'(num) >= (RW'(den) << Q_W);
    end
  end

  for (genvar k = 1; k <= Q_W; k++) begin : g_step
    logic [RW-1:0] trial;
    logic          ge;
    assign trial = RW'(dv[k-1]) << (Q_W - k);
    assign ge    = rem[k-1] >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        ovf[k] <= ovf[k-1];
        qb[k]  <= ge ? (qb[k-1] | (Q_W'(1) << (Q_W - k))) : qb[k-1];
      end
    end

    if (k < Q_W) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          dv[k]  <= dv[k-1];
          rem[k] <= ge ? rem[k-1] - trial : rem[k-1];
        end
      end
    end
  end

  assign quo = ovf[Q_W] ? '1 : qb[Q_W];

endmodule

FILE: design/blinn_phong_light_shade.sv
// Throughput: one item per cycle; the whole pipeline holds only while a
// result sits on the output and out_stall is high.
// Depth is set by the 31-step square root, two restoring dividers and the
// two-multiply-per-bit power chain.
// Reset (synchronous) clears all valid bits; payload registers are not reset.
module blinn_phong_light_shade #(
  parameter int unsigned SHININESS_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [47:0] light_dir,
  input  logic [47:0] view_dir,
  input  logic [47:0] surface_normal,
  input  logic [47:0] light_rgb,
  input  logic [47:0] diffuse_rgb,
  input  logic [47:0] specular_rgb,
  input  logic [7:0]  shininess,
  input  logic [31:0] attenuation,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] red,
  output logic [15:0] green,
  output logic [15:0] blue
);

  localparam int unsigned SB       = SHININESS_BITS;
  localparam int unsigned SQ_STEPS = bps_pkg::SQ_STEPS;
  localparam int unsigned ROOT_W   = bps_pkg::ROOT_W;
  localparam int unsigned REM_W    = bps_pkg::REM_W;
  localparam int unsigned RAD_W    = bps_pkg::RAD_W;
  localparam int unsigned DNH_W    = bps_pkg::DNH_W;
  localparam int unsigned Q14_W    = bps_pkg::Q14_W;

  localparam int unsigned R_SUM  = 3;
  localparam int unsigned R_SQE  = R_SUM + SQ_STEPS;
  localparam int unsigned ND_LAT = Q14_W + 1;
  localparam int unsigned R_DVE  = R_SQE + ND_LAT;
  localparam int unsigned R_PWE  = R_DVE + 2 * SB;
  localparam int unsigned R_F2   = R_PWE + 2;
  localparam int unsigned R_F3   = R_PWE + 3;
  localparam int unsigned CH_LAT = 17;
  localparam int unsigned NR     = R_F3 + CH_LAT + 1;

  typedef struct packed {
    logic [47:0]      lcol;
    logic [47:0]      kd;
    logic [47:0]      ks;
    logic [31:0]      att;
    logic [SB-1:0]    expo;
    bps_pkg::q14_t    ndotl;
  } side_t;

  logic          adv;
  logic [NR:1]   vld;
  side_t         side_q [1:R_F3];

  assign adv       = !(vld[NR] && out_stall);
  assign in_stall  = !adv;
  assign out_valid = vld[NR];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NR-1:1], in_valid};
    end
  end

  // rank 1: capture, half vector
  logic signed [15:0] l_q [3];
  logic signed [15:0] n_q [3];
  logic signed [16:0] h_q [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        l_q[c] <= $signed(light_dir[16*c +: 16]);
        n_q[c] <= $signed(surface_normal[16*c +: 16]);
        h_q[c] <= 17'($signed(light_dir[16*c +: 16])) -
                  17'($signed(view_dir[16*c +: 16]));
      end
      side_q[1] <= '{lcol: light_rgb, kd: diffuse_rgb, ks: specular_rgb,
                     att: attenuation, expo: SB'(shininess), ndotl: '0};
    end
  end

  // rank 2: component products
  logic signed [31:0] pnl [3];
  logic signed [32:0] pnh [3];
  logic signed [33:0] phh [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        pnl[c] <= 32'(n_q[c]) * 32'(l_q[c]);
        pnh[c] <= 33'(n_q[c]) * 33'(h_q[c]);
        phh[c] <= 34'(h_q[c]) * 34'(h_q[c]);
      end
    end
  end

  // rank 3: dot products, length squared, clamped n.l
  logic signed [33:0] dnl_sum;
  logic signed [34:0] dnh_sum;
  logic [RAD_W-1:0]   len2_sum;
  logic [18:0]        ndl_raw;
  bps_pkg::q14_t      ndotl_c;
  logic               nh_ok;
  side_t              side_ndl;

  assign dnl_sum  = 34'(pnl[0]) + 34'(pnl[1]) + 34'(pnl[2]);
  assign dnh_sum  = 35'(pnh[0]) + 35'(pnh[1]) + 35'(pnh[2]);
  assign len2_sum = RAD_W'(phh[0][32:0]) + RAD_W'(phh[1][32:0]) +
                    RAD_W'(phh[2][32:0]);
  assign ndl_raw  = dnl_sum[32:14];
  assign ndotl_c  = (dnl_sum <= 0) ? '0 :
                    (ndl_raw > 19'(bps_pkg::Q14_ONE)) ? bps_pkg::Q14_ONE :
                    ndl_raw[Q14_W-1:0];
  assign nh_ok    = (dnh_sum > 0) && (len2_sum != '0);

  always_comb begin
    side_ndl       = side_q[R_SUM-1];
    side_ndl.ndotl = ndotl_c;
  end

  for (genvar k = 2; k <= R_F3; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (adv) begin
        side_q[k] <= (k == R_SUM) ? side_ndl : side_q[k-1];
      end
    end
  end

  // square root of len2 * 2^28, one result bit per rank
  logic [RAD_W-1:0]  sq_rad  [0:SQ_STEPS-1];
  logic [REM_W-1:0]  sq_rem  [0:SQ_STEPS-1];
  logic [ROOT_W-1:0] sq_root [0:SQ_STEPS];
  logic [DNH_W-1:0]  sq_dnh  [0:SQ_STEPS];

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_rad[0]  <= len2_sum;
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
      sq_dnh[0]  <= nh_ok ? dnh_sum[DNH_W-1:0] : '0;
    end
  end

  for (genvar k = 1; k <= SQ_STEPS; k++) begin : g_sqrt
    logic [REM_W+1:0] cur;
    logic [REM_W+1:0] trial;
    logic             ge;
    assign cur   = {sq_rem[k-1], sq_rad[k-1][RAD_W-1 -: 2]};
    assign trial = {2'b00, sq_root[k-1], 2'b01};
    assign ge    = cur >= trial;

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_root[k] <= {sq_root[k-1][ROOT_W-2:0], ge};
        sq_dnh[k]  <= sq_dnh[k-1];
      end
    end

    if (k < SQ_STEPS) begin : g_rem
      always_ff @(posedge clk) begin
        if (adv) begin
          sq_rad[k] <= sq_rad[k-1] << 2;
          sq_rem[k] <= ge ? REM_W'(cur - trial) : cur[REM_W-1:0];
        end
      end
    end
  end

  // n.h / |h|; a zero root only occurs with a zero numerator
  logic [ROOT_W-1:0] nd_den;
  logic [Q14_W-1:0]  nd_quo;
  bps_pkg::q14_t     ndoth_c;

  assign nd_den = (sq_root[SQ_STEPS] == '0) ? ROOT_W'(1) : sq_root[SQ_STEPS];

  bps_udiv #(
    .NUM_W (DNH_W + 14),
    .DEN_W (ROOT_W),
    .Q_W   (Q14_W)
  ) u_ndoth_div (
    .clk (clk),
    .en  (adv),
    .num ({sq_dnh[SQ_STEPS], 14'b0}),
    .den (nd_den),
    .quo (nd_quo)
  );

  assign ndoth_c = (nd_quo > bps_pkg::Q14_ONE) ? bps_pkg::Q14_ONE : nd_quo;

  // power by square-and-multiply, two ranks per exponent bit
  bps_pkg::q14_t pw_acc  [1:2*SB];
  bps_pkg::q14_t pw_base [1:2*SB-1];

  for (genvar t = 0; t < SB; t++) begin : g_pow
    localparam int unsigned MS = 2 * t + 1;
    localparam int unsigned MM = 2 * t + 2;
    bps_pkg::q14_t acc_in;
    bps_pkg::q14_t base_in;

    if (t == 0) begin : g_first
      assign acc_in  = bps_pkg::Q14_ONE;
      assign base_in = ndoth_c;
    end else begin : g_next
      assign acc_in  = pw_acc[MS-1];
      assign base_in = pw_base[MS-1];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        pw_acc[MS]  <= bps_pkg::q14_mul(acc_in, acc_in);
        pw_base[MS] <= base_in;
        pw_acc[MM]  <= side_q[R_DVE+MS].expo[SB-1-t] ?
                       bps_pkg::q14_mul(pw_acc[MS], pw_base[MS]) : pw_acc[MS];
      end
    end

    if (t < SB - 1) begin : g_base
      always_ff @(posedge clk) begin
        if (adv) begin
          pw_base[MM] <= pw_base[MS];
        end
      end
    end
  end

  // per channel: kd*ndotl + ks*spec, then light * sum
  logic [30:0] prd_d  [3];
  logic [30:0] prd_s  [3];
  logic [31:0] sum_s  [3];
  logic [47:0] prod_p [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        prd_d[c]  <= 31'(side_q[R_PWE].kd[16*c +: 16]) * 31'(side_q[R_PWE].ndotl);
        prd_s[c]  <= 31'(side_q[R_PWE].ks[16*c +: 16]) * 31'(pw_acc[2*SB]);
        sum_s[c]  <= 32'(prd_d[c]) + 32'(prd_s[c]);
        prod_p[c] <= 48'(side_q[R_F2].lcol[16*c +: 16]) * 48'(sum_s[c]);
      end
    end
  end

  // floor(P / (att * 2^10)) = floor((P >> 10) / att)
  logic [15:0] ch_quo [3];

  for (genvar c = 0; c < 3; c++) begin : g_chan
    bps_udiv #(
      .NUM_W (38),
      .DEN_W (32),
      .Q_W   (16)
    ) u_ch_div (
      .clk (clk),
      .en  (adv),
      .num (prod_p[c][47:10]),
      .den (side_q[R_F3].att),
      .quo (ch_quo[c])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      red   <= ch_quo[0];
      green <= ch_quo[1];
      blue  <= ch_quo[2];
    end
  end

endmodule

FILE: design/bps_chk.sv
`include "assert_macros.svh"

module bps_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] red,
  input logic [15:0] green,
  input logic [15:0] blue
);

  // hold a stalled result and its value
  `BPS_ASSERT(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid)
  `BPS_ASSERT(a_out_stable, clk, rst, out_valid && out_stall |=> $stable(red) && $stable(green) && $stable(blue))
  // input side stalls exactly when the output transfer is blocked
  `BPS_ASSERT(a_backpressure, clk, rst, in_stall == (out_valid && out_stall))
  `BPS_ASSERT_NR(a_reset_empty, clk, rst |=> !out_valid)

endmodule

bind blinn_phong_light_shade bps_chk u_bps_chk (.*);
